// File: hw/rtl/ahfe_pkg.sv
// ----------------------------------------------------------------------------
// ahfe_pkg
// shared types, codes and character tables of the ascii header frame extractor
// ----------------------------------------------------------------------------
package ahfe_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int HDR_LEN     = 4;
    localparam int MIN_LEN     = 6;

    localparam logic [7:0] HEADER_SUM = 8'h83;
    localparam logic [7:0] CHR_LT     = 8'h3C; // '<'
    localparam logic [7:0] CHR_COLON  = 8'h3A; // ':'
    localparam logic [7:0] CHR_ZERO   = 8'h30; // '0'
    localparam logic [7:0] CHR_NINE   = 8'h39; // '9'

    typedef enum logic {
        OP_RX   = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_BAD_SUM = 3'd2,
        ST_BAD_LEN = 3'd3,
        ST_READ    = 3'd4
    } stat_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    // key tracker: 0..9 letters matched, then these codes
    localparam logic [3:0] KEY_ALL  = 4'd10;
    localparam logic [3:0] KEY_OK   = 4'd11;
    localparam logic [3:0] KEY_FAIL = 4'd12;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } item_t;

    function automatic logic [7:0] hdr_char(input logic [1:0] k);
        logic [7:0] c;
        unique case (k)
            2'd0: c = 8'h3C; // '<'
            2'd1: c = 8'h6D; // 'm'
            2'd2: c = 8'h73; // 's'
            2'd3: c = 8'h67; // 'g'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] k);
        logic [7:0] c;
        unique case (k)
            4'd0: c = 8'h64;    // 'd'
            4'd1: c = 8'h65;    // 'e'
            4'd2: c = 8'h76;    // 'v'
            4'd3: c = 8'h69;    // 'i'
            4'd4: c = 8'h63;    // 'c'
            4'd5: c = 8'h65;    // 'e'
            4'd6: c = 8'h4E;    // 'N'
            4'd7: c = 8'h61;    // 'a'
            4'd8: c = 8'h6D;    // 'm'
            4'd9: c = 8'h65;    // 'e'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ahfe_front.sv
// ----------------------------------------------------------------------------
// ahfe_front
// input side: takes transfers, tags them as receive or read, two-entry queue
// ----------------------------------------------------------------------------
module ahfe_front
    import ahfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_action,
    input  logic [7:0]  in_byte,
    input  logic [6:0]  in_index,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      new_item;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        new_item.op         = in_action ? OP_READ : OP_RX;
        new_item.rx_byte    = in_byte;
        new_item.read_index = in_index;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: hw/rtl/ahfe_back.sv
// ----------------------------------------------------------------------------
// ahfe_back
// frame engine: header hunt, length, checksum, key match, store and read
// ----------------------------------------------------------------------------
module ahfe_back
    import ahfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output stat_t       out_status,
    output logic [6:0]  out_length,
    output logic        out_key_flag,
    output logic [7:0]  out_data
);

    logic [7:0] store_mem [STORE_DEPTH];

    phase_t     phase_reg, phase_next;
    logic [1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [6:0] decl_reg, decl_next;
    logic [6:0] bcnt_reg, bcnt_next;
    logic [7:0] sum_reg, sum_next;
    logic [6:0] stored_reg, stored_next;
    logic [3:0] key_reg, key_next;
    logic       flag_reg, flag_next;

    logic       out_valid_reg;
    stat_t      out_status_reg;
    logic [6:0] out_len_reg;
    logic       out_flag_reg;
    logic       out_mem_reg;
    logic [7:0] out_const_reg;
    logic [7:0] mem_rd_reg;

    stat_t      status_next;
    logic       use_mem_next;
    logic [7:0] const_next;
    logic       mem_we, mem_re;
    logic [7:0] c;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] decl_sum;
    logic       finish;

    assign q_pop  = q_valid && (!out_valid_reg || out_ready);
    assign c      = q_item.rx_byte;
    assign is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
    assign digit  = 4'(c - CHR_ZERO);
    assign decl_sum = decl_reg + 7'(digit);

    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        decl_next    = decl_reg;
        bcnt_next    = bcnt_reg;
        sum_next     = sum_reg;
        stored_next  = stored_reg;
        key_next     = key_reg;
        flag_next    = flag_reg;
        status_next  = ST_BUSY;
        use_mem_next = 1'b0;
        const_next   = 8'h00;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        finish       = 1'b0;

        if (q_item.op == OP_READ) begin
            status_next = ST_READ;
            if (q_item.read_index < stored_reg) begin
                if (q_item.read_index < 7'(HDR_LEN)) begin
                    const_next = hdr_char(q_item.read_index[1:0]);
                end else if (9'(q_item.read_index) < 9'(STORE_DEPTH)) begin
                    use_mem_next = 1'b1;
                    mem_re       = 1'b1;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (c == hdr_char(hdr_cnt_reg)) begin
                        if (hdr_cnt_reg == 2'd3) begin
                            hdr_cnt_next = 2'd0;
                            phase_next   = PH_DIGITS;
                            bcnt_next    = 7'(HDR_LEN);
                            sum_next     = HEADER_SUM;
                            decl_next    = 7'd0;
                            key_next     = 4'd0;
                            stored_next  = 7'd0;
                            flag_next    = 1'b0;
                        end else begin
                            hdr_cnt_next = hdr_cnt_reg + 2'd1;
                        end
                    end else begin
                        hdr_cnt_next = (c == CHR_LT) ? 2'd1 : 2'd0;
                    end
                end
                PH_DIGITS: begin
                    mem_we   = (9'(bcnt_reg) < 9'(STORE_DEPTH));
                    sum_next = sum_reg + c;
                    if (bcnt_reg == 7'(HDR_LEN)) begin
                        decl_next = is_digit ? 7'(7'(digit) * 7'd10) : 7'h7F;
                        bcnt_next = 7'd5;
                    end else begin
                        bcnt_next = 7'd6;
                        if (!is_digit || decl_reg > 7'd90) begin
                            phase_next  = PH_HUNT;
                            status_next = ST_BAD_LEN;
                        end else begin
                            decl_next = decl_sum;
                            if (decl_sum < 7'(MIN_LEN) ||
                                9'(decl_sum) > 9'(STORE_DEPTH)) begin
                                phase_next  = PH_HUNT;
                                status_next = ST_BAD_LEN;
                            end else if (decl_sum == 7'(MIN_LEN)) begin
                                finish = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    mem_we   = (9'(bcnt_reg) < 9'(STORE_DEPTH));
                    sum_next = sum_reg + c;
                    if (key_reg < KEY_ALL) begin
                        key_next = (c == key_char(key_reg)) ? key_reg + 4'd1 : KEY_FAIL;
                    end else if (key_reg == KEY_ALL && c == CHR_COLON) begin
                        key_next = KEY_OK;
                    end
                    bcnt_next = bcnt_reg + 7'd1;
                    finish    = (bcnt_next >= decl_reg);
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase

            if (finish) begin
                phase_next = PH_HUNT;
                if (sum_next != 8'h00) begin
                    status_next = ST_BAD_SUM;
                end else begin
                    status_next = ST_ACCEPT;
                    stored_next = decl_next;
                    flag_next   = (key_next == KEY_OK);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            hdr_cnt_reg   <= 2'd0;
            decl_reg      <= 7'd0;
            bcnt_reg      <= 7'd0;
            sum_reg       <= 8'h00;
            stored_reg    <= 7'd0;
            key_reg       <= 4'd0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                decl_reg      <= decl_next;
                bcnt_reg      <= bcnt_next;
                sum_reg       <= sum_next;
                stored_reg    <= stored_next;
                key_reg       <= key_next;
                flag_reg      <= flag_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, held while the receiver stalls
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_status_reg <= status_next;
            out_len_reg    <= stored_next;
            out_flag_reg   <= flag_next;
            out_mem_reg    <= use_mem_next;
            out_const_reg  <= const_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && mem_we) begin
            store_mem[ADDR_W'(bcnt_reg)] <= c;
        end
        if (q_pop && mem_re) begin
            mem_rd_reg <= store_mem[ADDR_W'(q_item.read_index)];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_length   = out_len_reg;
    assign out_key_flag = out_flag_reg;
    assign out_data     = out_mem_reg ? mem_rd_reg : out_const_reg;

    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == ST_ACCEPT |-> out_len_reg >= 7'(MIN_LEN))
        else $error("accepted frame shorter than header and digits");

    a_drop_hunts: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (status_next == ST_ACCEPT || status_next == ST_BAD_SUM ||
                  status_next == ST_BAD_LEN) |=> phase_reg == PH_HUNT)
        else $error("frame end did not return to hunting");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> bcnt_reg < decl_reg)
        else $error("body byte count ran past declared length");

    a_key_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_reg |-> stored_reg != 7'd0)
        else $error("key flag set without a stored frame");

endmodule

// File: hw/rtl/ascii_header_frame_extractor_unit.sv
// ----------------------------------------------------------------------------
// ascii_header_frame_extractor_unit
// finds "<msg" frames in a byte stream, checks them and serves stored bytes
// ----------------------------------------------------------------------------
// usage
//   slave channel: each transfer is one action; s_tuser low means a received
//   byte in s_tdata[7:0], s_tuser high means a read of the stored frame at
//   offset s_tdata[14:8]
//   master channel: exactly one result transfer per slave transfer, in order;
//   m_tuser carries the status code, m_tdata the stored frame length, the
//   device name key flag and the read byte
//   path: a taken transfer passes through the queue, then the engine's result
//   register with the store read port
//   throughput: one transfer per cycle sustained while m_tready stays high, set by the single
//   per-byte state update and the one read/write port of the frame store
//   reset: hunting for a header, no stored frame (length 0, all reads give 0);
//   the frame store needs no clearing pass
//   stall: while m_tready is low the result is held; the two-entry queue
//   keeps taking transfers until it is full, then s_tready drops
// ----------------------------------------------------------------------------
module ascii_header_frame_extractor_unit
    import ahfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] frame_length, [7] is_device_name_key,
                                   // [15:8] read_data
    output logic [2:0]  m_tuser    // [2:0] status
);

    item_t      q_item;
    logic       q_valid;
    logic       q_pop;
    stat_t      out_status;
    logic [6:0] out_length;
    logic       out_key_flag;
    logic [7:0] out_data;

    // front end: accepts and tags transfers into the short queue
    ahfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser[0]),
        .in_byte   (s_tdata[7:0]),
        .in_index  (s_tdata[14:8]),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // back end: frame engine, store and result register
    ahfe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_length   (out_length),
        .out_key_flag (out_key_flag),
        .out_data     (out_data)
    );

    assign m_tuser = out_status;
    assign m_tdata = {out_data, out_key_flag, out_length};

endmodule
